FILE: rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants for the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    // field widths and fixed-point format
    localparam int COORD_W    = 16;
    localparam int COORD_FRAC = 14;
    localparam int POLAR_W    = 11;
    localparam int AZIM_W     = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CORDIC_XW  = 34;
    localparam int MAX_STAGES = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLICES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RINGS  = 1'b1;

    localparam logic [CFG_W-1:0] SLICES_RESET = 11'd16;
    localparam logic [CFG_W-1:0] RINGS_RESET  = 11'd8;

    // CORDIC start value: gain 0.607252935 in Q30
    localparam logic signed [CORDIC_XW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic signed [COORD_W-1:0] COORD_LIM = 16'sd16384;

    typedef struct packed {
        logic [POLAR_W-1:0] polar_step;
        logic [AZIM_W-1:0]  azimuth_step;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      index_ok;
    } vtx_t;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic ok;
    } ctl_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turn(input int unsigned i);
        logic signed [31:0] a;
        case (i)
            0:  a = 32'sh20000000;
            1:  a = 32'sh12E4051E;
            2:  a = 32'sh09FB385B;
            3:  a = 32'sh051111D4;
            4:  a = 32'sh028B0D43;
            5:  a = 32'sh0145D7E1;
            6:  a = 32'sh00A2F61E;
            7:  a = 32'sh00517C55;
            8:  a = 32'sh0028BE53;
            9:  a = 32'sh00145F2F;
            10: a = 32'sh000A2F98;
            11: a = 32'sh000517CC;
            12: a = 32'sh00028BE6;
            13: a = 32'sh000145F3;
            14: a = 32'sh0000A2FA;
            15: a = 32'sh0000517D;
            16: a = 32'sh000028BE;
            17: a = 32'sh0000145F;
            18: a = 32'sh00000A30;
            19: a = 32'sh00000518;
            20: a = 32'sh0000028C;
            21: a = 32'sh00000146;
            22: a = 32'sh000000A3;
            23: a = 32'sh00000051;
            24: a = 32'sh00000029;
            25: a = 32'sh00000014;
            26: a = 32'sh0000000A;
            27: a = 32'sh00000005;
            28: a = 32'sh00000003;
            29: a = 32'sh00000001;
            30: a = 32'sh00000001;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_div #(
    parameter int QW = 17,
    parameter int NW = 28,
    parameter int DW = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  uvs_pkg::ctl_t     ctl_in,
    input  logic [NW-1:0]     num_p,
    input  logic [DW-1:0]     den_p,
    input  logic [NW-1:0]     num_a,
    input  logic [DW-1:0]     den_a,
    output uvs_pkg::ctl_t     ctl_out,
    output logic [QW-1:0]     q_p,
    output logic [QW-1:0]     q_a
);
    import uvs_pkg::*;

    ctl_t          ctl_reg [0:QW];
    logic [DW-1:0] rem_reg [0:1][0:QW];
    logic [QW-1:0] low_reg [0:1][0:QW];
    logic [DW-1:0] den_reg [0:1][0:QW];

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 0; k < QW; k++)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    // load: high part of the dividend starts the remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0][0] <= DW'(num_p >> QW);
            low_reg[0][0] <= num_p[QW-1:0];
            den_reg[0][0] <= den_p;
            rem_reg[1][0] <= DW'(num_a >> QW);
            low_reg[1][0] <= num_a[QW-1:0];
            den_reg[1][0] <= den_a;
        end
    end

    // one trial subtract per stage and lane
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        for (genvar k = 0; k < QW; k++)
        begin : g_stage
            logic [DW:0] trial;
            logic        ge;

            always_comb
            begin
                trial = {rem_reg[l][k], low_reg[l][k][QW-1]};
                ge    = trial >= {1'b0, den_reg[l][k]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][k+1] <= ge ? DW'(trial - {1'b0, den_reg[l][k]})
                                          : trial[DW-1:0];
                    low_reg[l][k+1] <= {low_reg[l][k][QW-2:0], ge};
                    den_reg[l][k+1] <= den_reg[l][k];
                end
            end
        end
    end

    assign ctl_out = ctl_reg[QW];
    assign q_p     = low_reg[0][QW];
    assign q_a     = low_reg[1][QW];

endmodule

FILE: rtl/core/uvs_cordic.sv
// ----------------------------------------------------------------------------
// uvs_cordic
// Two-lane pipelined rotation CORDIC giving cosine and sine in Q30.
// ----------------------------------------------------------------------------
module uvs_cordic #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  uvs_pkg::ctl_t                           ctl_in,
    input  logic [ANGLE_BITS-1:0]                   ph_p,
    input  logic [ANGLE_BITS-1:0]                   ph_a,
    output uvs_pkg::ctl_t                           ctl_out,
    output logic signed [uvs_pkg::CORDIC_XW-1:0]    cos_p,
    output logic signed [uvs_pkg::CORDIC_XW-1:0]    sin_p,
    output logic signed [uvs_pkg::CORDIC_XW-1:0]    cos_a,
    output logic signed [uvs_pkg::CORDIC_XW-1:0]    sin_a
);
    import uvs_pkg::*;

    localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    ctl_t                        ctl_reg  [0:NS+1];
    logic signed [CORDIC_XW-1:0] x_reg    [0:1][0:NS];
    logic signed [CORDIC_XW-1:0] y_reg    [0:1][0:NS];
    logic signed [31:0]          z_reg    [0:1][0:NS];
    logic [1:0]                  quad_reg [0:1][0:NS];
    logic signed [CORDIC_XW-1:0] c_reg    [0:1];
    logic signed [CORDIC_XW-1:0] s_reg    [0:1];
    logic [ANGLE_BITS-1:0]       ph       [0:1];

    assign ph[0] = ph_p;
    assign ph[1] = ph_a;

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS + 1; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 0; k <= NS; k++)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [31:0] turn;

        // phase to 32-bit turn; top two bits pick the quadrant
        assign turn = 32'(ph[l]) << (32 - ANGLE_BITS);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[l][0]    <= GAIN_Q30;
                y_reg[l][0]    <= '0;
                z_reg[l][0]    <= signed'({2'b00, turn[29:0]});
                quad_reg[l][0] <= turn[31:30];
            end
        end

        // micro-rotations
        for (genvar i = 0; i < NS; i++)
        begin : g_stage
            logic signed [CORDIC_XW-1:0] dx;
            logic signed [CORDIC_XW-1:0] dy;

            assign dx = y_reg[l][i] >>> i;
            assign dy = x_reg[l][i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_reg[l][i] >= 0)
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] - dx;
                        y_reg[l][i+1] <= y_reg[l][i] + dy;
                        z_reg[l][i+1] <= z_reg[l][i] - atan_turn(i);
                    end
                    else
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] + dx;
                        y_reg[l][i+1] <= y_reg[l][i] - dy;
                        z_reg[l][i+1] <= z_reg[l][i] + atan_turn(i);
                    end
                    quad_reg[l][i+1] <= quad_reg[l][i];
                end
            end
        end

        // quadrant fold
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                case (quad_reg[l][NS])
                    2'd0:
                    begin
                        c_reg[l] <= x_reg[l][NS];
                        s_reg[l] <= y_reg[l][NS];
                    end
                    2'd1:
                    begin
                        c_reg[l] <= -y_reg[l][NS];
                        s_reg[l] <= x_reg[l][NS];
                    end
                    2'd2:
                    begin
                        c_reg[l] <= -x_reg[l][NS];
                        s_reg[l] <= -y_reg[l][NS];
                    end
                    default:
                    begin
                        c_reg[l] <= y_reg[l][NS];
                        s_reg[l] <= -x_reg[l][NS];
                    end
                endcase
            end
        end
    end

    assign ctl_out = ctl_reg[NS+1];
    assign cos_p   = c_reg[0];
    assign sin_p   = s_reg[0];
    assign cos_a   = c_reg[1];
    assign sin_a   = s_reg[1];

endmodule

FILE: rtl/core/uvs_out.sv
// ----------------------------------------------------------------------------
// uvs_out
// Product stage and round/saturate stage that form the vertex coordinates.
// ----------------------------------------------------------------------------
module uvs_out (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  uvs_pkg::ctl_t                           ctl_in,
    input  logic signed [uvs_pkg::CORDIC_XW-1:0]    cos_p,
    input  logic signed [uvs_pkg::CORDIC_XW-1:0]    sin_p,
    input  logic signed [uvs_pkg::CORDIC_XW-1:0]    cos_a,
    input  logic signed [uvs_pkg::CORDIC_XW-1:0]    sin_a,
    output logic                                    vtx_valid,
    output uvs_pkg::vtx_t                           vtx
);
    import uvs_pkg::*;

    ctl_t                        ctl1_reg;
    ctl_t                        ctl2_reg;
    logic signed [63:0]          px_reg;
    logic signed [63:0]          pz_reg;
    logic signed [CORDIC_XW-1:0] cy_reg;
    vtx_t                        vtx_reg;
    vtx_t                        vtx_next;
    logic signed [31:0]          sp32;
    logic signed [31:0]          ca32;
    logic signed [31:0]          sa32;

    // round half up, then clamp to +-1.0
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [63:0] v,
        input int unsigned        sh
    );
        logic signed [63:0] t;
        logic signed [63:0] lim;
        lim = 64'sd1 <<< COORD_FRAC;
        t   = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (t > lim)
        begin
            t = lim;
        end
        if (t < -lim)
        begin
            t = -lim;
        end
        return t[COORD_W-1:0];
    endfunction

    // Q30 values stay within 32 signed bits
    assign sp32 = sin_p[31:0];
    assign ca32 = cos_a[31:0];
    assign sa32 = sin_a[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    // products in Q60
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= sp32 * ca32;
            pz_reg <= sp32 * sa32;
            cy_reg <= cos_p;
        end
    end

    always_comb
    begin
        vtx_next = '0;
        if (ctl1_reg.ok)
        begin
            vtx_next.coord_x  = round_sat(px_reg, 60 - COORD_FRAC);
            vtx_next.coord_y  = round_sat(64'(cy_reg), 30 - COORD_FRAC);
            vtx_next.coord_z  = round_sat(pz_reg, 60 - COORD_FRAC);
            vtx_next.index_ok = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vtx_reg <= vtx_next;
        end
    end

    assign vtx_valid = ctl2_reg.valid;
    assign vtx       = vtx_reg;

endmodule

FILE: rtl/core/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Unit-sphere vertex from a polar and an azimuth step, Q1.14 output.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | polar_step, azimuth_step
//  vtx     | out       | vtx_valid/vtx_stall  | coord_x/y/z, index_ok
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled. The pipeline
// has a load stage ahead of the divider and of the CORDIC, one divider
// stage per quotient bit, one CORDIC stage per micro-rotation (at most
// 32), then fold, product and rounding stages.
// Reset clears all valid bits and loads slices 16, rings 8.
// A stalled output transaction freezes the whole pipeline; nothing moves.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
    parameter int MAX_DIVISIONS = 1024,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  uvs_pkg::req_t                   req,
    output logic                            vtx_valid,
    input  logic                            vtx_stall,
    output uvs_pkg::vtx_t                   vtx,
    input  logic                            cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]       cfg_data
);
    import uvs_pkg::*;

    localparam int QW = ANGLE_BITS + 1;
    localparam int DW = CFG_W + 1;
    localparam int NW = POLAR_W + ANGLE_BITS + 1;

    logic [CFG_W-1:0]            slices_reg;
    logic [CFG_W-1:0]            rings_reg;
    logic                        en;
    logic                        ok;
    ctl_t                        ctl_in;
    ctl_t                        ctl_div;
    ctl_t                        ctl_cor;
    logic [NW-1:0]               num_p;
    logic [NW-1:0]               num_a;
    logic [DW-1:0]               den_p;
    logic [DW-1:0]               den_a;
    logic [QW-1:0]               q_p;
    logic [QW-1:0]               q_a;
    logic signed [CORDIC_XW-1:0] cos_p;
    logic signed [CORDIC_XW-1:0] sin_p;
    logic signed [CORDIC_XW-1:0] cos_a;
    logic signed [CORDIC_XW-1:0] sin_a;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slices_reg <= SLICES_RESET;
            rings_reg  <= RINGS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLICES: slices_reg <= cfg_data;
                REG_RINGS:  rings_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // pipeline advances unless the output is held
    assign en        = !(vtx_valid && vtx_stall);
    assign req_stall = !en;

    // range check of registers and indices
    always_comb
    begin
        ok = (slices_reg >= CFG_W'(3))
          && (32'(slices_reg) <= 32'(MAX_DIVISIONS))
          && (rings_reg >= CFG_W'(2))
          && (32'(rings_reg) <= 32'(MAX_DIVISIONS))
          && (req.polar_step <= rings_reg)
          && (CFG_W'(req.azimuth_step) < slices_reg);
        ctl_in.valid = req_valid;
        ctl_in.ok    = ok;
    end

    // phase = (r*2^A + rings) / (2*rings) and (j*2^A + slices/2) / slices
    assign num_p = (NW'(req.polar_step) << ANGLE_BITS) + NW'(rings_reg);
    assign den_p = {rings_reg, 1'b0};
    assign num_a = (NW'(req.azimuth_step) << ANGLE_BITS) + NW'(slices_reg >> 1);
    assign den_a = DW'(slices_reg);

    uvs_div #(
        .QW (QW),
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .num_p   (num_p),
        .den_p   (den_p),
        .num_a   (num_a),
        .den_a   (den_a),
        .ctl_out (ctl_div),
        .q_p     (q_p),
        .q_a     (q_a)
    );

    uvs_cordic #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_div),
        .ph_p    (q_p[ANGLE_BITS-1:0]),
        .ph_a    (q_a[ANGLE_BITS-1:0]),
        .ctl_out (ctl_cor),
        .cos_p   (cos_p),
        .sin_p   (sin_p),
        .cos_a   (cos_a),
        .sin_a   (sin_a)
    );

    uvs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_cor),
        .cos_p     (cos_p),
        .sin_p     (sin_p),
        .cos_a     (cos_a),
        .sin_a     (sin_a),
        .vtx_valid (vtx_valid),
        .vtx       (vtx)
    );

    // out-of-range transactions carry zero coordinates
    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && !vtx.index_ok |->
            vtx.coord_x == '0 && vtx.coord_y == '0 && vtx.coord_z == '0)
        else $error("nonzero coordinates on an out-of-range vertex");

    // saturation keeps every coordinate within +-1.0
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid |->
            vtx.coord_x <= COORD_LIM && vtx.coord_x >= -COORD_LIM &&
            vtx.coord_y <= COORD_LIM && vtx.coord_y >= -COORD_LIM &&
            vtx.coord_z <= COORD_LIM && vtx.coord_z >= -COORD_LIM)
        else $error("vertex coordinate out of range");

endmodule
